// ----- hdl/astc_pkg.sv -----
// Shared types and constants for the accelerometer swing trigger classifier.
// Used by every module of the block; no dependencies of its own.
package astc_pkg;

  // Default depth of the turn-mark window.
  localparam int WINDOW_DEF = 7;

  localparam int AXIS_W   = 16;
  localparam int ENERGY_W = 32;
  localparam int LIMIT_W  = 3;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  // Register reset values (levels are squared raw-count magnitudes).
  localparam logic [LIMIT_W-1:0]  STRONG_LIMIT_RST = 3'd2;
  localparam logic [LIMIT_W-1:0]  WEAK_LIMIT_RST   = 3'd0;
  localparam logic [ENERGY_W-1:0] SWING_LEVEL_RST  = 32'd10737091;
  localparam logic [ENERGY_W-1:0] STRONG_LEVEL_RST = 32'd1052342246;

  typedef enum logic [1:0] {
    SLOPE_FLAT = 2'd0,
    SLOPE_UP   = 2'd1,
    SLOPE_DOWN = 2'd2
  } slope_t;

  typedef enum logic [1:0] {
    MARK_NONE   = 2'd0,
    MARK_STRONG = 2'd1,
    MARK_WEAK   = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    CLASS_NONE   = 2'd0,
    CLASS_SWING  = 2'd1,
    CLASS_STRONG = 2'd2
  } class_t;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_STRONG_LIMIT = 2'd0,
    REG_WEAK_LIMIT   = 2'd1,
    REG_SWING_LEVEL  = 2'd2,
    REG_STRONG_LEVEL = 2'd3
  } cfg_reg_t;

endpackage

// ----- hdl/astc_mark_cell.sv -----
// One cell of the turn-mark window: holds one mark and hands it to its neighbor.
// Depends on astc_pkg for the mark type.
module astc_mark_cell
  import astc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift_en,
  input  mark_t mark_in,
  output mark_t mark_out
);

  mark_t mark_r;
  mark_t mark_nxt;

  // Take the neighbor's mark on every accepted sample.
  always_comb begin
    mark_nxt = mark_r;
    if (shift_en) begin
      mark_nxt = mark_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= MARK_NONE;
    end else begin
      mark_r <= mark_nxt;
    end
  end

  assign mark_out = mark_r;

endmodule

// ----- hdl/astc_energy.sv -----
// Two-stage squared-magnitude unit: squares of the axes, then their sum.
// Depends on astc_pkg for widths; valid/ready on both sides.
module astc_energy
  import astc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [AXIS_W-1:0]   accel_x,
  input  logic signed [AXIS_W-1:0]   accel_y,
  input  logic signed [AXIS_W-1:0]   accel_z,
  output logic                       e_valid,
  input  logic                       e_ready,
  output logic        [ENERGY_W-1:0] e_data
);

  logic                a_valid_r, a_valid_nxt;
  logic                b_valid_r, b_valid_nxt;
  logic                a_ready, b_ready;
  logic [AXIS_W-1:0]   mag_x, mag_y, mag_z;
  logic [ENERGY_W-1:0] sq_x_r, sq_y_r, sq_z_r;
  logic [ENERGY_W-1:0] e_r;

  // Magnitude of each axis; the most negative value maps to 32768 unsigned.
  always_comb begin
    mag_x = accel_x[AXIS_W-1] ? AXIS_W'(-accel_x) : accel_x;
    mag_y = accel_y[AXIS_W-1] ? AXIS_W'(-accel_y) : accel_y;
    mag_z = accel_z[AXIS_W-1] ? AXIS_W'(-accel_z) : accel_z;
  end

  // Stage handshake: a stage loads when it is empty or its content moves on.
  assign b_ready  = !b_valid_r || e_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    a_valid_nxt = a_valid_r;
    b_valid_nxt = b_valid_r;
    if (a_ready) begin
      a_valid_nxt = in_valid;
    end
    if (b_ready) begin
      b_valid_nxt = a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  // Square stage.
  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      sq_x_r <= ENERGY_W'(mag_x) * ENERGY_W'(mag_x);
      sq_y_r <= ENERGY_W'(mag_y) * ENERGY_W'(mag_y);
      sq_z_r <= ENERGY_W'(mag_z) * ENERGY_W'(mag_z);
    end
  end

  // Sum stage; the total is at most 3 * 2^30, so no carry is lost.
  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      e_r <= sq_x_r + sq_y_r + sq_z_r;
    end
  end

  assign e_valid = b_valid_r;
  assign e_data  = e_r;

endmodule

// ----- hdl/accel_swing_trigger_classifier_core.sv -----
// Accelerometer swing trigger classifier, top level.
// Pipeline: an input transfer passes the square, sum and classify registers to result valid.
// Throughput: one sample per cycle while the result channel takes results; the classify
// stage updates the mark chain and the running turn counts together for each sample.
// Reset (synchronous, rst_n low): registers to defaults, window cleared,
// next sample treated as the first; no clearing pass is needed.
module accel_swing_trigger_classifier_core
  import astc_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input channel.
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [AXIS_W-1:0]   in_accel_x,
  input  logic signed [AXIS_W-1:0]   in_accel_y,
  input  logic signed [AXIS_W-1:0]   in_accel_z,
  // Result channel.
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic        [1:0]          out_trigger_class,
  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic        [CFG_AW-1:0]   paddr,
  input  logic        [CFG_DW-1:0]   pwdata,
  output logic        [CFG_DW-1:0]   prdata,
  output logic                       pready
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // Configuration registers.
  logic [LIMIT_W-1:0]  strong_limit_r;
  logic [LIMIT_W-1:0]  weak_limit_r;
  logic [ENERGY_W-1:0] swing_level_r;
  logic [ENERGY_W-1:0] strong_level_r;
  logic                cfg_wr;
  cfg_reg_t            cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strong_limit_r <= STRONG_LIMIT_RST;
      weak_limit_r   <= WEAK_LIMIT_RST;
      swing_level_r  <= SWING_LEVEL_RST;
      strong_level_r <= STRONG_LEVEL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_STRONG_LIMIT: strong_limit_r <= pwdata[LIMIT_W-1:0];
        REG_WEAK_LIMIT:   weak_limit_r   <= pwdata[LIMIT_W-1:0];
        REG_SWING_LEVEL:  swing_level_r  <= pwdata;
        REG_STRONG_LEVEL: strong_level_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_sel)
      REG_STRONG_LIMIT: prdata = CFG_DW'(strong_limit_r);
      REG_WEAK_LIMIT:   prdata = CFG_DW'(weak_limit_r);
      REG_SWING_LEVEL:  prdata = swing_level_r;
      REG_STRONG_LEVEL: prdata = strong_level_r;
      default:          prdata = '0;
    endcase
  end

  // Energy front end.
  logic                e_valid;
  logic                e_ready;
  logic [ENERGY_W-1:0] e_data;

  astc_energy u_energy (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .accel_x  (in_accel_x),
    .accel_y  (in_accel_y),
    .accel_z  (in_accel_z),
    .e_valid  (e_valid),
    .e_ready  (e_ready),
    .e_data   (e_data)
  );

  // Classify stage handshake: the output register parts it from the consumer.
  logic   out_valid_r, out_valid_nxt;
  class_t out_class_r, out_class_nxt;
  logic   fire_c;

  assign e_ready = !out_valid_r || out_ready;
  assign fire_c  = e_valid && e_ready;

  // Slope tracking state.
  logic [ENERGY_W-1:0] prev_energy_r, prev_energy_nxt;
  slope_t              prev_slope_r, prev_slope_nxt;
  logic                first_pending_r, first_pending_nxt;
  slope_t              slope_raw, slope;
  mark_t               mark_new;

  // Slope of the energy and the turn mark for the sample in this stage.
  always_comb begin
    if (e_data > prev_energy_r) begin
      slope_raw = SLOPE_UP;
    end else if (e_data < prev_energy_r) begin
      slope_raw = SLOPE_DOWN;
    end else begin
      slope_raw = SLOPE_FLAT;
    end
    slope    = first_pending_r ? SLOPE_FLAT : slope_raw;
    mark_new = MARK_NONE;
    if (!first_pending_r &&
        ((slope_raw == SLOPE_UP && prev_slope_r == SLOPE_DOWN) ||
         (slope_raw == SLOPE_DOWN && prev_slope_r == SLOPE_UP))) begin
      mark_new = (e_data > swing_level_r) ? MARK_STRONG : MARK_WEAK;
    end
  end

  // Row of mark cells; the last cell holds the oldest mark in the window.
  mark_t             chain [WINDOW];
  logic [WINDOW-1:0] strong_vec;
  logic [WINDOW-1:0] weak_vec;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    astc_mark_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (fire_c),
      .mark_in  ((i == 0) ? mark_new : chain[(i == 0) ? 0 : i - 1]),
      .mark_out (chain[i])
    );
    assign strong_vec[i] = (chain[i] == MARK_STRONG);
    assign weak_vec[i]   = (chain[i] == MARK_WEAK);
  end

  // Running counts: add the entering mark, drop the one leaving the window.
  logic [CNT_W-1:0] strong_cnt_r, strong_cnt_nxt;
  logic [CNT_W-1:0] weak_cnt_r, weak_cnt_nxt;
  logic [CNT_W-1:0] strong_cnt_upd, weak_cnt_upd;

  always_comb begin
    strong_cnt_upd = strong_cnt_r
                   + CNT_W'(mark_new == MARK_STRONG)
                   - CNT_W'(chain[WINDOW-1] == MARK_STRONG);
    weak_cnt_upd   = weak_cnt_r
                   + CNT_W'(mark_new == MARK_WEAK)
                   - CNT_W'(chain[WINDOW-1] == MARK_WEAK);
  end

  // Next state and the class of the sample in this stage.
  always_comb begin
    strong_cnt_nxt    = strong_cnt_r;
    weak_cnt_nxt      = weak_cnt_r;
    prev_energy_nxt   = prev_energy_r;
    prev_slope_nxt    = prev_slope_r;
    first_pending_nxt = first_pending_r;
    out_class_nxt     = out_class_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    if (fire_c) begin
      strong_cnt_nxt    = strong_cnt_upd;
      weak_cnt_nxt      = weak_cnt_upd;
      prev_energy_nxt   = e_data;
      prev_slope_nxt    = slope;
      first_pending_nxt = 1'b0;
      out_valid_nxt     = 1'b1;
      if (CMP_W'(strong_cnt_upd) > CMP_W'(strong_limit_r) ||
          e_data > strong_level_r) begin
        out_class_nxt = CLASS_STRONG;
      end else if (CMP_W'(weak_cnt_upd) > CMP_W'(weak_limit_r)) begin
        out_class_nxt = CLASS_NONE;
      end else begin
        out_class_nxt = CLASS_SWING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strong_cnt_r    <= '0;
      weak_cnt_r      <= '0;
      prev_energy_r   <= '0;
      prev_slope_r    <= SLOPE_FLAT;
      first_pending_r <= 1'b1;
      out_valid_r     <= 1'b0;
    end else begin
      strong_cnt_r    <= strong_cnt_nxt;
      weak_cnt_r      <= weak_cnt_nxt;
      prev_energy_r   <= prev_energy_nxt;
      prev_slope_r    <= prev_slope_nxt;
      first_pending_r <= first_pending_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Class register holds payload only.
  always_ff @(posedge clk) begin
    out_class_r <= out_class_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_trigger_class = out_class_r;

  // The running counts always agree with the marks held in the cells.
  a_strong_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    strong_cnt_r == CNT_W'($countones(strong_vec)))
    else $error("strong turn count disagrees with mark chain");

  a_weak_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    weak_cnt_r == CNT_W'($countones(weak_vec)))
    else $error("weak turn count disagrees with mark chain");

  // A classified sample always leaves a pending result and clears first-sample state.
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire_c |=> (out_valid_r && !first_pending_r))
    else $error("classified sample did not produce a result");

  // The first sample after reset never leaves a turn mark.
  a_first_no_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (fire_c && first_pending_r) |=> (chain[0] == MARK_NONE))
    else $error("first sample marked a turn");

endmodule
